FILE: hdl/npce_pkg.sv
package npce_pkg;

    // Default pulse counts for the escape preamble and the end code.
    localparam int PREAMBLE_PULSES_DEF = 2;
    localparam int END_PULSES_DEF = 2;

    // Nibble counts after the escape offset reach at most 30.
    localparam int NCW = 5;
    localparam int CNT_MAX = 30;

    // Depth of the queue between the front and back parts.
    localparam int QDEPTH = 2;
    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QLW = $clog2(QDEPTH + 1);

    // Command codes.
    localparam logic [1:0] CMD_BYTE     = 2'd0;
    localparam logic [1:0] CMD_BYTE_END = 2'd1;
    localparam logic [1:0] CMD_END_ONLY = 2'd2;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    // Pulse kinds.
    localparam logic [1:0] KIND_HIGH = 2'd0;
    localparam logic [1:0] KIND_LOW  = 2'd1;
    localparam logic [1:0] KIND_ALT  = 2'd2;

    // Phases.
    localparam logic [1:0] PH_PRE  = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_END  = 2'd2;

    // Byte masks and the zero nibble.
    localparam logic [7:0] HI_MASK  = 8'hF0;
    localparam logic [7:0] LO_MASK  = 8'h0F;
    localparam logic [3:0] NIB_ZERO = 4'h0;

    // Reset value of the escape offset register.
    localparam logic [3:0] ESC_OFFSET_RST = 4'd1;

    // One classified command: which pulse trains it still needs.
    typedef struct packed {
        logic           pre;
        logic [NCW-1:0] hi;
        logic [NCW-1:0] lo;
        logic           fin;
    } desc_t;

    // Write side of the queue.
    typedef struct packed {
        logic  valid;
        desc_t desc;
    } q_push_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic           full;
        logic           empty;
        logic [QLW-1:0] level;
    } q_stat_t;

endpackage

FILE: hdl/npce_ifs.sv
interface npce_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface npce_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] pulse_kind;
    logic [1:0] phase;
    logic       last;

    modport source (output valid, output pulse_kind, output phase, output last, input ready);
    modport sink (input valid, input pulse_kind, input phase, input last, output ready);
endinterface

FILE: hdl/npce_front.sv
module npce_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [3:0]       cfg_wdata,
    npce_in_if.sink          in_ch,
    input  npce_pkg::q_stat_t q_stat,
    output npce_pkg::q_push_t q_push
);
    import npce_pkg::*;

    logic [3:0] esc_offset_reg;
    logic [3:0] hi_nib;
    logic [3:0] lo_nib;
    logic [3:0] add;
    logic       has_byte;
    logic       esc;

    // Escape offset register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_offset_reg <= ESC_OFFSET_RST;
        end
        else if (cfg_we)
        begin
            esc_offset_reg <= cfg_wdata;
        end
    end

    // A beat is taken whenever the queue has room.
    assign in_ch.ready = !q_stat.full;

    // Split the byte and decide whether the escape form is needed.
    always_comb
    begin
        hi_nib   = 4'((in_ch.data_byte & HI_MASK) >> 4);
        lo_nib   = 4'(in_ch.data_byte & LO_MASK);
        has_byte = (in_ch.cmd == CMD_BYTE) || (in_ch.cmd == CMD_BYTE_END);
        esc      = has_byte && ((hi_nib == NIB_ZERO) || (lo_nib == NIB_ZERO));
        add      = esc ? esc_offset_reg : NIB_ZERO;

        q_push.desc.pre = esc;
        q_push.desc.hi  = has_byte ? ({1'b0, hi_nib} + {1'b0, add}) : '0;
        q_push.desc.lo  = has_byte ? ({1'b0, lo_nib} + {1'b0, add}) : '0;
        q_push.desc.fin = (in_ch.cmd == CMD_BYTE_END) || (in_ch.cmd == CMD_END_ONLY);

        // The unused command produces no pulses and is dropped here.
        q_push.valid = in_ch.valid && in_ch.ready && (in_ch.cmd != CMD_UNUSED);
    end

endmodule

FILE: hdl/npce_fifo.sv
module npce_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  npce_pkg::q_push_t q_push,
    input  logic              pop,
    output npce_pkg::desc_t   head,
    output npce_pkg::q_stat_t q_stat
);
    import npce_pkg::*;

    desc_t          entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QLW-1:0] level_reg;
    logic           do_push;
    logic           do_pop;

    assign q_stat.full  = (level_reg == QLW'(QDEPTH));
    assign q_stat.empty = (level_reg == '0);
    assign q_stat.level = level_reg;
    assign head         = entry_reg[rd_ptr_reg];

    assign do_push = q_push.valid && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= q_push.desc;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/npce_back.sv
module npce_back #(
    parameter int PREAMBLE_PULSES = npce_pkg::PREAMBLE_PULSES_DEF,
    parameter int END_PULSES = npce_pkg::END_PULSES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  npce_pkg::desc_t   head,
    input  npce_pkg::q_stat_t q_stat,
    output logic              pop,
    output logic              idle,
    npce_out_if.source        out_ch
);
    import npce_pkg::*;

    localparam int ALT_MAX = (PREAMBLE_PULSES > END_PULSES) ? PREAMBLE_PULSES : END_PULSES;
    localparam int LEN_MAX = (ALT_MAX > CNT_MAX) ? ALT_MAX : CNT_MAX;
    localparam int CW = $clog2(LEN_MAX + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PRE  = 5'b00010,
        ST_HIGH = 5'b00100,
        ST_LOW  = 5'b01000,
        ST_END  = 5'b10000
    } state_t;

    typedef struct packed {
        state_t        state;
        logic [CW-1:0] len;
        desc_t         rest;
    } seg_t;

    state_t        state_reg;
    logic [CW-1:0] cnt_reg;
    desc_t         pend_reg;
    logic          out_valid_reg;
    logic [1:0]    kind_reg;
    logic [1:0]    phase_reg;
    logic          last_reg;

    desc_t         src;
    seg_t          seg;
    logic          adv;
    logic          emit;
    logic          seg_done;

    // Choose the next pulse train still pending, in output order.
    function automatic seg_t pick(desc_t d);
        seg_t s;
        s.rest = d;
        s.len  = '0;
        if (d.pre)
        begin
            s.state    = ST_PRE;
            s.len      = CW'(PREAMBLE_PULSES);
            s.rest.pre = 1'b0;
        end
        else if (d.hi != '0)
        begin
            s.state   = ST_HIGH;
            s.len     = CW'(d.hi);
            s.rest.hi = '0;
        end
        else if (d.lo != '0)
        begin
            s.state   = ST_LOW;
            s.len     = CW'(d.lo);
            s.rest.lo = '0;
        end
        else if (d.fin)
        begin
            s.state    = ST_END;
            s.len      = CW'(END_PULSES);
            s.rest.fin = 1'b0;
        end
        else
        begin
            s.state = ST_IDLE;
        end
        return s;
    endfunction

    assign adv      = !out_valid_reg || out_ch.ready;
    assign idle     = (state_reg == ST_IDLE);
    assign emit     = !idle && adv;
    assign pop      = idle && !q_stat.empty && adv;
    assign seg_done = (cnt_reg == '0);
    assign src      = idle ? head : pend_reg;
    assign seg      = pick(src);

    // Sequencer over the pulse trains of one command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else if (pop || (emit && seg_done))
        begin
            state_reg <= seg.state;
            cnt_reg   <= seg.len - CW'(1);
        end
        else if (emit)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    // Pending trains of the command being sent.
    always_ff @(posedge clk)
    begin
        if (pop || (emit && seg_done))
        begin
            pend_reg <= seg.rest;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= !idle;
        end
    end

    // Output payload for the current pulse.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            last_reg <= seg_done && (seg.state == ST_IDLE);
            case (state_reg)
                ST_PRE:
                begin
                    kind_reg  <= KIND_ALT;
                    phase_reg <= PH_PRE;
                end
                ST_HIGH:
                begin
                    kind_reg  <= KIND_HIGH;
                    phase_reg <= PH_DATA;
                end
                ST_LOW:
                begin
                    kind_reg  <= KIND_LOW;
                    phase_reg <= PH_DATA;
                end
                ST_END:
                begin
                    kind_reg  <= KIND_ALT;
                    phase_reg <= PH_END;
                end
                default:
                begin
                    kind_reg  <= KIND_ALT;
                    phase_reg <= PH_END;
                end
            endcase
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.pulse_kind = kind_reg;
    assign out_ch.phase      = phase_reg;
    assign out_ch.last       = last_reg;

endmodule

FILE: hdl/nibble_pulse_count_encoder.sv
// The first pulse follows the queue write, the sequencer load and the output register.
// Throughput: a command of 2 to 49 pulses (default counts) holds the sequencer for one
// load step, then sends one pulse a cycle while the output is not stalled.
// A two-entry queue lets new commands be accepted while earlier ones are still sent.
// Reset: escape offset returns to 1, the queue empties and no pulse is pending.
module nibble_pulse_count_encoder #(
    parameter int PREAMBLE_PULSES = npce_pkg::PREAMBLE_PULSES_DEF,
    parameter int END_PULSES = npce_pkg::END_PULSES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    npce_in_if.sink    in_ch,
    npce_out_if.source out_ch
);
    import npce_pkg::*;

    q_push_t q_push;
    q_stat_t q_stat;
    desc_t   head;
    logic    pop;
    logic    back_idle;

    // Front part: register, classification and push.
    npce_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .q_stat    (q_stat),
        .q_push    (q_push)
    );

    // Queue between the two parts.
    npce_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .pop    (pop),
        .head   (head),
        .q_stat (q_stat)
    );

    // Back part: pulse sequencer and output register.
    npce_back #(
        .PREAMBLE_PULSES (PREAMBLE_PULSES),
        .END_PULSES      (END_PULSES)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .idle   (back_idle),
        .out_ch (out_ch)
    );

    // The front never pushes into a full queue.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push.valid |-> !q_stat.full)
        else $error("push into full queue");

    // The fill level never exceeds the queue depth.
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.level <= QLW'(QDEPTH))
        else $error("queue level out of range");

    // An idle sequencer with a waiting command and a free output starts it.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (back_idle && !q_stat.empty && (!out_ch.valid || out_ch.ready)) |=> !back_idle)
        else $error("sequencer did not start a waiting command");

    // Preamble and end code pulses are always of the alternating kind.
    a_alt_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.phase == PH_PRE || out_ch.phase == PH_END))
        |-> (out_ch.pulse_kind == KIND_ALT))
        else $error("wrong pulse kind for preamble or end code");

endmodule
